// ===== hdl/rmth_pkg.sv =====
// ----------------------------------------------------------------------------
// rmth_pkg: shared constants and types for the running median unit
// Heap geometry, index widths and the command record that the control
// sequencer hands to the sift engine.
// ----------------------------------------------------------------------------
package rmth_pkg;

   localparam int CAPACITY   = 1024;
   localparam int HEAP_DEPTH = (CAPACITY + 1) / 2;
   localparam int IDX_W      = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
   localparam int SIZE_W     = $clog2(HEAP_DEPTH + 1);
   localparam int CHILD_W    = IDX_W + 2;
   localparam int TOTAL_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W     = 32;
   localparam int MEDIAN_W   = 33;
   localparam int COUNT_W    = 11;

   typedef struct packed {
      logic              start;
      logic              replace;   // 1: replace top and sift down, 0: push
      logic              lower;     // 1: lower max-heap, 0: upper min-heap
      logic [DATA_W-1:0] value;     // sign-flipped sample
      logic [SIZE_W-1:0] size;      // current size of the selected heap
   } sift_cmd_type;

endpackage

// ===== hdl/rmth_ram.sv =====
// ----------------------------------------------------------------------------
// rmth_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rmth_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== hdl/rmth_sift.sv =====
// ----------------------------------------------------------------------------
// rmth_sift: heap sift engine
// Owns both heap RAMs and runs one push (sift up) or replace-top (sift down)
// at a time with a single shared rank comparator. Tracks both heap tops.
// ----------------------------------------------------------------------------
module rmth_sift (
   input  logic                              clock,
   input  logic                              reset,
   input  rmth_pkg::sift_cmd_type            cmd,
   output logic                              done,
   output logic [rmth_pkg::DATA_W-1:0]       lower_top,
   output logic [rmth_pkg::DATA_W-1:0]       upper_top
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_UP     = 3'd1;
   localparam logic [2:0] S_UP_CMP = 3'd2;
   localparam logic [2:0] S_DN     = 3'd3;
   localparam logic [2:0] S_DN_L   = 3'd4;
   localparam logic [2:0] S_DN_R   = 3'd5;
   localparam logic [2:0] S_DN_CMP = 3'd6;

   logic [2:0]                    state_ff, state_in;
   logic                          lower_ff, lower_in;
   logic [rmth_pkg::DATA_W-1:0]   val_ff, val_in;
   logic [rmth_pkg::SIZE_W-1:0]   size_ff, size_in;
   logic [rmth_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic [rmth_pkg::IDX_W-1:0]    nidx_ff, nidx_in;    // parent or chosen child
   logic [rmth_pkg::DATA_W-1:0]   cand_ff, cand_in;
   logic [rmth_pkg::DATA_W-1:0]   ltop_ff, ltop_in;
   logic [rmth_pkg::DATA_W-1:0]   utop_ff, utop_in;

   logic                          wr_en;
   logic [rmth_pkg::IDX_W-1:0]    wr_addr;
   logic [rmth_pkg::DATA_W-1:0]   wr_data;
   logic [rmth_pkg::IDX_W-1:0]    rd_addr;
   logic [rmth_pkg::DATA_W-1:0]   rd_lo, rd_up, rd_data;
   logic [rmth_pkg::DATA_W-1:0]   cmp_a, cmp_b;
   logic                          cmp_above;
   logic [rmth_pkg::CHILD_W-1:0]  left_c, right_c, size_c;
   logic [rmth_pkg::IDX_W-1:0]    parent;

   rmth_ram #(.WIDTH(rmth_pkg::DATA_W), .DEPTH(rmth_pkg::HEAP_DEPTH)) u_lower_ram (
      .clock (clock),
      .we    (wr_en & lower_ff),
      .waddr (wr_addr),
      .wdata (wr_data),
      .raddr (rd_addr),
      .rdata (rd_lo)
   );

   rmth_ram #(.WIDTH(rmth_pkg::DATA_W), .DEPTH(rmth_pkg::HEAP_DEPTH)) u_upper_ram (
      .clock (clock),
      .we    (wr_en & ~lower_ff),
      .waddr (wr_addr),
      .wdata (wr_data),
      .raddr (rd_addr),
      .rdata (rd_up)
   );

   assign rd_data   = lower_ff ? rd_lo : rd_up;
   assign cmp_above = lower_ff ? (cmp_a > cmp_b) : (cmp_a < cmp_b);
   assign left_c    = rmth_pkg::CHILD_W'({idx_ff, 1'b1});
   assign right_c   = left_c + rmth_pkg::CHILD_W'(1);
   assign size_c    = rmth_pkg::CHILD_W'(size_ff);
   assign parent    = (idx_ff - rmth_pkg::IDX_W'(1)) >> 1;

   assign lower_top = ltop_ff;
   assign upper_top = utop_ff;

   always_comb begin
      state_in = state_ff;
      lower_in = lower_ff;
      val_in   = val_ff;
      size_in  = size_ff;
      idx_in   = idx_ff;
      nidx_in  = nidx_ff;
      cand_in  = cand_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff;
      wr_data  = val_ff;
      rd_addr  = left_c[rmth_pkg::IDX_W-1:0];
      cmp_a    = val_ff;
      cmp_b    = rd_data;
      done     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               lower_in = cmd.lower;
               val_in   = cmd.value;
               size_in  = cmd.size;
               if (cmd.replace) begin
                  idx_in   = '0;
                  state_in = S_DN;
               end else begin
                  idx_in   = cmd.size[rmth_pkg::IDX_W-1:0];
                  state_in = S_UP;
               end
            end
         end
         S_UP: begin
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               done     = 1'b1;
               state_in = S_IDLE;
            end else begin
               rd_addr  = parent;
               nidx_in  = parent;
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            // move the parent down into the hole while the new value ranks above
            if (cmp_above) begin
               wr_en    = 1'b1;
               wr_data  = rd_data;
               idx_in   = nidx_ff;
               state_in = S_UP;
            end else begin
               wr_en    = 1'b1;
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DN: begin
            if (left_c >= size_c) begin
               wr_en    = 1'b1;
               done     = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_DN_L;
            end
         end
         S_DN_L: begin
            cand_in = rd_data;
            nidx_in = left_c[rmth_pkg::IDX_W-1:0];
            if (right_c < size_c) begin
               rd_addr  = right_c[rmth_pkg::IDX_W-1:0];
               state_in = S_DN_R;
            end else begin
               state_in = S_DN_CMP;
            end
         end
         S_DN_R: begin
            cmp_a = rd_data;
            cmp_b = cand_ff;
            if (cmp_above) begin
               cand_in = rd_data;
               nidx_in = right_c[rmth_pkg::IDX_W-1:0];
            end
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            cmp_a = cand_ff;
            cmp_b = val_ff;
            if (cmp_above) begin
               wr_en    = 1'b1;
               wr_data  = cand_ff;
               idx_in   = nidx_ff;
               state_in = S_DN;
            end else begin
               wr_en    = 1'b1;
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      ltop_in = ltop_ff;
      utop_in = utop_ff;
      if (wr_en && wr_addr == '0) begin
         if (lower_ff) begin
            ltop_in = wr_data;
         end else begin
            utop_in = wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      lower_ff <= lower_in;
      val_ff   <= val_in;
      size_ff  <= size_in;
      idx_ff   <= idx_in;
      nidx_ff  <= nidx_in;
      cand_ff  <= cand_in;
      ltop_ff  <= ltop_in;
      utop_ff  <= utop_in;
   end

endmodule

// ===== hdl/running_median_two_heaps_unit.sv =====
// ----------------------------------------------------------------------------
// running_median_two_heaps_unit: running median over a two-heap store
// A dropped item goes straight to the result; any other item first runs an
//   optional replace-top (sift down) and then a push (sift up) in the sift
//   engine, each over at most 9 levels in a 512-entry heap.
// Throughput: one item at a time; ready again once its result is registered,
//   which waits while the previous result is stalled.
// Reset clears heap sizes and control; heap RAM contents are not cleared.
// ----------------------------------------------------------------------------
module running_median_two_heaps_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [rmth_pkg::DATA_W-1:0]  req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [rmth_pkg::MEDIAN_W-1:0] rsp_median_doubled,
   output logic [rmth_pkg::COUNT_W-1:0]        rsp_stored_count,
   output logic                                rsp_dropped
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ISSUE1 = 3'd1;
   localparam logic [2:0] S_WAIT1  = 3'd2;
   localparam logic [2:0] S_ISSUE2 = 3'd3;
   localparam logic [2:0] S_WAIT2  = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0]                      state_ff, state_in;
   logic [rmth_pkg::SIZE_W-1:0]     lsize_ff, lsize_in;
   logic [rmth_pkg::SIZE_W-1:0]     usize_ff, usize_in;
   logic                            rep_lower_ff, rep_lower_in;  // heap whose top is replaced
   logic                            push_lower_ff, push_lower_in;
   logic [rmth_pkg::DATA_W-1:0]     sample_ff, sample_in;        // value for the replace
   logic [rmth_pkg::DATA_W-1:0]     push_val_ff, push_val_in;
   logic                            dropped_ff, dropped_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [rmth_pkg::MEDIAN_W-1:0]   median_ff, median_in;
   logic [rmth_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic                            drop_out_ff, drop_out_in;

   rmth_pkg::sift_cmd_type          cmd;
   logic                            sift_done;
   logic [rmth_pkg::DATA_W-1:0]     lower_top, upper_top;
   logic [rmth_pkg::DATA_W-1:0]     v;
   logic [rmth_pkg::TOTAL_W-1:0]    total;
   logic                            halves_equal;
   logic [rmth_pkg::MEDIAN_W-1:0]   raw_twice;

   rmth_sift u_sift (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .done      (sift_done),
      .lower_top (lower_top),
      .upper_top (upper_top)
   );

   // flip the sign bit so unsigned order matches signed order
   assign v            = {~req_sample[rmth_pkg::DATA_W-1], req_sample[rmth_pkg::DATA_W-2:0]};
   assign total        = rmth_pkg::TOTAL_W'(lsize_ff) + rmth_pkg::TOTAL_W'(usize_ff);
   assign halves_equal = (lsize_ff == usize_ff);

   // tops are biased by 2^31 each; toggling bit 32 removes 2^32 modulo 2^33
   assign raw_twice = halves_equal
                    ? ({1'b0, lower_top} + {1'b0, upper_top})
                    : {upper_top, 1'b0};

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_median_doubled = median_ff;
   assign rsp_stored_count   = count_ff;
   assign rsp_dropped        = drop_out_ff;

   always_comb begin
      state_in      = state_ff;
      lsize_in      = lsize_ff;
      usize_in      = usize_ff;
      rep_lower_in  = rep_lower_ff;
      push_lower_in = push_lower_ff;
      sample_in     = sample_ff;
      push_val_in   = push_val_ff;
      dropped_in    = dropped_ff;
      rsp_valid_in  = rsp_valid_ff;
      median_in     = median_ff;
      count_in      = count_ff;
      drop_out_in   = drop_out_ff;

      cmd.start   = 1'b0;
      cmd.replace = 1'b0;
      cmd.lower   = push_lower_ff;
      cmd.value   = push_val_ff;
      cmd.size    = push_lower_ff ? lsize_ff : usize_ff;

      // drop the result once it is taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               sample_in  = v;
               dropped_in = 1'b0;
               if (total >= rmth_pkg::TOTAL_W'(rmth_pkg::CAPACITY)) begin
                  // store full: discard the sample, report the stored set
                  dropped_in = 1'b1;
                  state_in   = S_DONE;
               end else if (halves_equal) begin
                  push_lower_in = 1'b0;
                  if (lsize_ff != '0 && v < lower_top) begin
                     // lower top moves up, sample takes its place
                     rep_lower_in = 1'b1;
                     push_val_in  = lower_top;
                     state_in     = S_ISSUE1;
                  end else begin
                     push_val_in = v;
                     state_in    = S_ISSUE2;
                  end
               end else begin
                  push_lower_in = 1'b1;
                  if (v <= upper_top) begin
                     push_val_in = v;
                     state_in    = S_ISSUE2;
                  end else begin
                     // upper top moves down, sample takes its place
                     rep_lower_in = 1'b0;
                     push_val_in  = upper_top;
                     state_in     = S_ISSUE1;
                  end
               end
            end
         end
         S_ISSUE1: begin
            cmd.start   = 1'b1;
            cmd.replace = 1'b1;
            cmd.lower   = rep_lower_ff;
            cmd.value   = sample_ff;
            cmd.size    = rep_lower_ff ? lsize_ff : usize_ff;
            state_in    = S_WAIT1;
         end
         S_WAIT1: begin
            if (sift_done) begin
               state_in = S_ISSUE2;
            end
         end
         S_ISSUE2: begin
            cmd.start = 1'b1;
            state_in  = S_WAIT2;
         end
         S_WAIT2: begin
            if (sift_done) begin
               // advance the size of the heap that took the push
               if (push_lower_ff) begin
                  lsize_in = lsize_ff + rmth_pkg::SIZE_W'(1);
               end else begin
                  usize_in = usize_ff + rmth_pkg::SIZE_W'(1);
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               median_in    = {~raw_twice[rmth_pkg::MEDIAN_W-1],
                               raw_twice[rmth_pkg::MEDIAN_W-2:0]};
               count_in     = rmth_pkg::COUNT_W'(total);
               drop_out_in  = dropped_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lsize_ff     <= '0;
         usize_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lsize_ff     <= lsize_in;
         usize_ff     <= usize_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rep_lower_ff  <= rep_lower_in;
      push_lower_ff <= push_lower_in;
      sample_ff     <= sample_in;
      push_val_ff   <= push_val_in;
      dropped_ff    <= dropped_in;
      median_ff     <= median_in;
      count_ff      <= count_in;
      drop_out_ff   <= drop_out_in;
   end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for running_median_two_heaps_unit
// Streams signed samples through the valid/ready input, predicts the median
// with a behavioral two-heap model and checks every result in order, with
// random idle cycles on both channels and a fill-up past store capacity.
// ----------------------------------------------------------------------------
module testbench;

   localparam int RANDOM_ITEMS = 1480;
   localparam int DRAIN_CYCLES = 200;   // well above the worst item latency

   typedef struct packed {
      logic [rmth_pkg::MEDIAN_W-1:0] median_doubled;
      logic [rmth_pkg::COUNT_W-1:0]  stored_count;
      logic                          dropped;
   } median_result_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic signed [rmth_pkg::DATA_W-1:0]   req_sample = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic signed [rmth_pkg::MEDIAN_W-1:0] rsp_median_doubled;
   logic [rmth_pkg::COUNT_W-1:0]         rsp_stored_count;
   logic                                 rsp_dropped;

   logic [rmth_pkg::DATA_W-1:0] sample_queue[$];
   median_result_type           median_queue[$];
   int                          accepted_count = 0;
   int                          error_count = 0;

   // Predictor state: heap 1 is the lower max-heap, heap 0 the upper
   // min-heap. Entries hold samples with the sign bit flipped.
   logic [rmth_pkg::DATA_W-1:0] heap_mem[2][rmth_pkg::HEAP_DEPTH];
   int                          heap_size[2];

   running_median_two_heaps_unit uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_median_doubled (rsp_median_doubled),
      .rsp_stored_count   (rsp_stored_count),
      .rsp_dropped        (rsp_dropped)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Heap predictor
   // ------------------------------------------------------------------------
   function automatic bit outranks(int h, logic [rmth_pkg::DATA_W-1:0] a,
                                   logic [rmth_pkg::DATA_W-1:0] b);
      return (h == 1) ? (a > b) : (a < b);
   endfunction

   function automatic void heap_push(int h, logic [rmth_pkg::DATA_W-1:0] v);
      int                          i;
      int                          p;
      logic [rmth_pkg::DATA_W-1:0] t;
      i = heap_size[h];
      heap_mem[h][i] = v;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (!outranks(h, heap_mem[h][i], heap_mem[h][p])) break;
         t = heap_mem[h][i];
         heap_mem[h][i] = heap_mem[h][p];
         heap_mem[h][p] = t;
         i = p;
      end
      heap_size[h]++;
   endfunction

   function automatic void heap_replace_top(int h, logic [rmth_pkg::DATA_W-1:0] v);
      int                          i;
      int                          l;
      int                          c;
      logic [rmth_pkg::DATA_W-1:0] t;
      i = 0;
      heap_mem[h][0] = v;
      forever begin
         l = 2 * i + 1;
         if (l >= heap_size[h]) break;
         c = l;
         if (l + 1 < heap_size[h] && outranks(h, heap_mem[h][l+1], heap_mem[h][l]))
            c = l + 1;
         if (!outranks(h, heap_mem[h][c], heap_mem[h][i])) break;
         t = heap_mem[h][i];
         heap_mem[h][i] = heap_mem[h][c];
         heap_mem[h][c] = t;
         i = c;
      end
   endfunction

   // Insert one sample and return the median of the stored set, doubled.
   function automatic median_result_type insert_sample(logic [rmth_pkg::DATA_W-1:0] sample);
      median_result_type           r;
      logic [rmth_pkg::DATA_W-1:0] v;
      logic [rmth_pkg::DATA_W-1:0] t;
      logic [63:0]                 twice;
      int                          total;
      v = sample ^ 32'h8000_0000;
      r.dropped = 1'b0;
      if (heap_size[0] + heap_size[1] >= rmth_pkg::CAPACITY) begin
         r.dropped = 1'b1;
      end else if (heap_size[1] == heap_size[0]) begin
         // tie with the lower top goes up
         if (heap_size[1] > 0 && v < heap_mem[1][0]) begin
            t = heap_mem[1][0];
            heap_replace_top(1, v);
            heap_push(0, t);
         end else begin
            heap_push(0, v);
         end
      end else begin
         // tie with the upper top goes down
         if (v <= heap_mem[0][0]) begin
            heap_push(1, v);
         end else begin
            t = heap_mem[0][0];
            heap_replace_top(0, v);
            heap_push(1, t);
         end
      end
      total = heap_size[0] + heap_size[1];
      if (total == 0)
         twice = '0;
      else if (heap_size[1] == heap_size[0])
         twice = {32'b0, heap_mem[1][0]} + {32'b0, heap_mem[0][0]} - 64'h1_0000_0000;
      else
         twice = {31'b0, heap_mem[0][0], 1'b0} - 64'h1_0000_0000;
      r.median_doubled = twice[rmth_pkg::MEDIAN_W-1:0];
      r.stored_count   = total[rmth_pkg::COUNT_W-1:0];
      return r;
   endfunction

   // Idle percentages: receiver-heavy phase, sender-heavy phase, then none.
   function automatic int sender_idle_pct();
      if (accepted_count < 500) return 31;
      if (accepted_count < 1000) return 60;
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (accepted_count < 500) return 60;
      if (accepted_count < 1000) return 31;
      return 0;
   endfunction

   // ------------------------------------------------------------------------
   // Driver: present the next pending item, hold it until accepted
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (sample_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
            req_sample <= sample_queue.pop_front();
            req_valid  <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall the result channel at random.
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct());
   end

   // ------------------------------------------------------------------------
   // Monitor: predict on each accepted sample, check each accepted result
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      median_result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            median_queue.push_back(insert_sample(req_sample));
            accepted_count <= accepted_count + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (median_queue.size() == 0) begin
               $display("%0t: result with nothing expected: median %0d count %0d dropped %0b",
                        $time, rsp_median_doubled, rsp_stored_count, rsp_dropped);
               error_count++;
            end else begin
               want = median_queue.pop_front();
               if (rsp_median_doubled !== want.median_doubled) begin
                  $display("%0t: median_doubled expected %0d actual %0d", $time,
                           $signed(want.median_doubled), rsp_median_doubled);
                  error_count++;
               end
               if (rsp_stored_count !== want.stored_count) begin
                  $display("%0t: stored_count expected %0d actual %0d", $time,
                           want.stored_count, rsp_stored_count);
                  error_count++;
               end
               if (rsp_dropped !== want.dropped) begin
                  $display("%0t: dropped expected %0b actual %0b", $time,
                           want.dropped, rsp_dropped);
                  error_count++;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      int unsigned pick;
      heap_size[0] = 0;
      heap_size[1] = 0;

      // Extremes first so the full-width sum of both tops is exercised.
      sample_queue.push_back(32'h7FFF_FFFF);
      sample_queue.push_back(32'h7FFF_FFFF);
      sample_queue.push_back(32'h8000_0000);
      sample_queue.push_back(32'h8000_0000);
      sample_queue.push_back(32'h8000_0000);
      sample_queue.push_back(32'h8000_0000);
      sample_queue.push_back(32'h7FFF_FFFF);
      sample_queue.push_back(32'h0000_0000);
      sample_queue.push_back(32'hFFFF_FFFF);
      sample_queue.push_back(32'h0000_0001);
      // Ties against each heap top.
      repeat (5) sample_queue.push_back(32'h0000_0000);
      sample_queue.push_back(32'hFFFF_FFFF);
      sample_queue.push_back(32'hFFFF_FFFF);
      sample_queue.push_back(32'h0000_0001);
      sample_queue.push_back(32'h0000_0001);
      sample_queue.push_back(32'h7FFF_FFFE);
      sample_queue.push_back(32'h8000_0001);
      sample_queue.push_back(32'h5555_5555);
      sample_queue.push_back(32'hAAAA_AAAA);

      // Random part; runs well past capacity so the full-store path is hit.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(99);
         if (pick < 40)
            sample_queue.push_back($urandom_range(16) - 8);
         else if (pick < 55)
            sample_queue.push_back(32'h7FFF_FFFF - $urandom_range(3));
         else if (pick < 70)
            sample_queue.push_back(32'h8000_0000 + $urandom_range(3));
         else
            sample_queue.push_back($urandom());
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (sample_queue.size() > 0 || req_valid) @(posedge clock);
      while (median_queue.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && median_queue.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog: about 1500 items at worst-case latency plus both stall rates.
   initial begin
      #4000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
